@@ src/lpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lpcs_pkg - shared types and ROM tables for the LPC lattice synthesizer
// Holds the coefficient, energy, period and chirp tables and the
// multiply-unit control word.
// ----------------------------------------------------------------------------
package lpcs_pkg;

    localparam int unsigned NUM_STAGES = 10;
    localparam int unsigned CHIRP_ROM_LEN = 41;
    localparam logic [15:0] LFSR_TAPS = 16'hB800;
    localparam logic [3:0] ENERGY_REST = 4'h0;
    localparam logic [3:0] ENERGY_STOP = 4'hF;
    localparam logic signed [15:0] CLAMP_HI = 16'sd511;
    localparam logic signed [15:0] CLAMP_LO = -16'sd512;
    localparam logic signed [7:0] DUTY_BIAS = 8'sh80;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Control word handed to the shared multiply unit.
    typedef struct packed {
        logic               wide;  // shift 15 instead of 7
        logic signed [15:0] coef;
        logic signed [15:0] data;
    } t_mul_req;

    function automatic logic [7:0] energy_rom(input logic [3:0] a);
        logic [7:0] t [16];
        t = '{8'h00,8'h02,8'h03,8'h04,8'h05,8'h07,8'h0a,8'h0f,
              8'h14,8'h20,8'h29,8'h39,8'h51,8'h72,8'ha1,8'hff};
        return t[a];
    endfunction

    function automatic logic [7:0] period_rom(input logic [5:0] a);
        logic [7:0] t [64];
        t = '{8'h00,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,
              8'h17,8'h18,8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h1E,
              8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,
              8'h27,8'h28,8'h29,8'h2A,8'h2B,8'h2D,8'h2F,8'h31,
              8'h33,8'h35,8'h36,8'h39,8'h3B,8'h3D,8'h3F,8'h42,
              8'h45,8'h47,8'h49,8'h4D,8'h4F,8'h51,8'h55,8'h57,
              8'h5C,8'h5F,8'h63,8'h66,8'h6A,8'h6E,8'h73,8'h77,
              8'h7B,8'h80,8'h85,8'h8A,8'h8F,8'h95,8'h9A,8'hA0};
        return t[a];
    endfunction

    function automatic logic signed [15:0] k1_rom(input logic [4:0] a);
        logic signed [15:0] t [32];
        t = '{-16'sd32064,-16'sd31872,-16'sd31808,-16'sd31680,
              -16'sd31552,-16'sd31424,-16'sd31232,-16'sd30848,
              -16'sd30592,-16'sd30336,-16'sd30016,-16'sd29696,
              -16'sd29376,-16'sd28928,-16'sd28480,-16'sd27968,
              -16'sd26368,-16'sd24256,-16'sd21632,-16'sd18368,
              -16'sd14528,-16'sd10048,-16'sd5184,16'sd0,
              16'sd5184,16'sd10048,16'sd14528,16'sd18368,
              16'sd21632,16'sd24256,16'sd26368,16'sd27968};
        return t[a];
    endfunction

    function automatic logic signed [15:0] k2_rom(input logic [4:0] a);
        logic signed [15:0] t [32];
        t = '{-16'sd20992,-16'sd19328,-16'sd17536,-16'sd15552,
              -16'sd13440,-16'sd11200,-16'sd8768,-16'sd6272,
              -16'sd3712,-16'sd1088,16'sd1536,16'sd4160,
              16'sd6720,16'sd9216,16'sd11584,16'sd13824,
              16'sd15936,16'sd17856,16'sd19648,16'sd21248,
              16'sd22656,16'sd24000,16'sd25152,16'sd26176,
              16'sd27072,16'sd27840,16'sd28544,16'sd29120,
              16'sd29632,16'sd30080,16'sd30464,16'sd32384};
        return t[a];
    endfunction

    // K3..K10 tables; sel picks K3 (0) .. K10 (7), a is the code.
    function automatic logic signed [7:0] kn_rom(input logic [2:0] sel,
                                                  input logic [3:0] a);
        logic signed [7:0] t3 [16];
        logic signed [7:0] t4 [16];
        logic signed [7:0] t5 [16];
        logic signed [7:0] t6 [16];
        logic signed [7:0] t7 [16];
        logic signed [7:0] t8 [8];
        logic signed [7:0] t9 [8];
        logic signed [7:0] t10 [8];
        logic signed [7:0] r;
        t3 = '{-8'sd110,-8'sd97,-8'sd83,-8'sd70,-8'sd56,-8'sd43,-8'sd29,-8'sd16,
               -8'sd2,8'sd11,8'sd25,8'sd38,8'sd52,8'sd65,8'sd79,8'sd92};
        t4 = '{-8'sd82,-8'sd68,-8'sd54,-8'sd40,-8'sd26,-8'sd12,8'sd1,8'sd15,
               8'sd29,8'sd43,8'sd57,8'sd71,8'sd85,8'sd99,8'sd113,8'sd126};
        t5 = '{-8'sd82,-8'sd70,-8'sd59,-8'sd47,-8'sd35,-8'sd24,-8'sd12,-8'sd1,
               8'sd11,8'sd23,8'sd34,8'sd46,8'sd57,8'sd69,8'sd81,8'sd92};
        t6 = '{-8'sd64,-8'sd53,-8'sd42,-8'sd31,-8'sd20,-8'sd9,8'sd3,8'sd14,
               8'sd25,8'sd36,8'sd47,8'sd58,8'sd69,8'sd80,8'sd91,8'sd102};
        t7 = '{-8'sd77,-8'sd65,-8'sd53,-8'sd41,-8'sd29,-8'sd17,-8'sd5,8'sd7,
               8'sd19,8'sd31,8'sd43,8'sd55,8'sd67,8'sd79,8'sd90,8'sd102};
        t8 = '{-8'sd64,-8'sd40,-8'sd16,8'sd7,8'sd31,8'sd55,8'sd79,8'sd102};
        t9 = '{-8'sd64,-8'sd44,-8'sd24,-8'sd4,8'sd16,8'sd37,8'sd57,8'sd77};
        t10 = '{-8'sd51,-8'sd33,-8'sd15,8'sd4,8'sd22,8'sd32,8'sd59,8'sd77};
        case (sel)
            3'd0: r = t3[a];
            3'd1: r = t4[a];
            3'd2: r = t5[a];
            3'd3: r = t6[a];
            3'd4: r = t7[a];
            3'd5: r = t8[a[2:0]];
            3'd6: r = t9[a[2:0]];
            3'd7: r = t10[a[2:0]];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [7:0] chirp_rom(input logic [5:0] a);
        logic signed [7:0] t [41];
        logic signed [7:0] r;
        t = '{8'sd0,8'sd42,-8'sd44,8'sd50,-8'sd78,8'sd18,8'sd37,8'sd20,
              8'sd2,-8'sd31,-8'sd59,8'sd2,8'sd95,8'sd90,8'sd5,8'sd15,
              8'sd38,-8'sd4,-8'sd91,-8'sd91,-8'sd42,-8'sd35,-8'sd36,-8'sd4,
              8'sd37,8'sd43,8'sd34,8'sd33,8'sd15,-8'sd1,-8'sd8,-8'sd18,
              -8'sd19,-8'sd17,-8'sd9,-8'sd10,-8'sd6,8'sd0,8'sd3,8'sd2,8'sd1};
        if (a < 6'(CHIRP_ROM_LEN)) r = t[a];
        else r = '0;
        return r;
    endfunction

endpackage

@@ src/lpcs_frame_dec.sv @@
// ----------------------------------------------------------------------------
// lpcs_frame_dec - LPC frame field decoder
// Cuts the left-aligned stream bits into energy, repeat, period and K codes
// and maps them through the ROM tables.
// ----------------------------------------------------------------------------
module lpcs_frame_dec #(
    parameter int unsigned FRAME_WIDTH = 50
) (
    input  logic [FRAME_WIDTH-1:0] i_bits,
    output logic [3:0]             o_energy_code,
    output logic [7:0]             o_energy,
    output logic                   o_repeat,
    output logic [7:0]             o_period,
    output logic signed [15:0]     o_k1,
    output logic signed [15:0]     o_k2,
    output logic signed [7:0]      o_kn [8]
);
    logic [49:0] w_top;
    logic [3:0]  w_code [8];

    // Fields live in the top 50 bits; FRAME_WIDTH >= 50.
    assign w_top = i_bits[FRAME_WIDTH-1 -: 50];
    assign o_energy_code = w_top[49:46];
    assign o_energy = lpcs_pkg::energy_rom(w_top[49:46]);
    assign o_repeat = w_top[45];
    assign o_period = lpcs_pkg::period_rom(w_top[44:39]);
    assign o_k1 = lpcs_pkg::k1_rom(w_top[38:34]);
    assign o_k2 = lpcs_pkg::k2_rom(w_top[33:29]);
    assign w_code[0] = w_top[28:25];
    assign w_code[1] = w_top[24:21];
    assign w_code[2] = w_top[20:17];
    assign w_code[3] = w_top[16:13];
    assign w_code[4] = w_top[12:9];
    assign w_code[5] = {1'b0, w_top[8:6]};
    assign w_code[6] = {1'b0, w_top[5:3]};
    assign w_code[7] = {1'b0, w_top[2:0]};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_kn[i] = lpcs_pkg::kn_rom(3'(i), w_code[i]);
        end
    end
endmodule

@@ src/lpcs_mul_unit.sv @@
// ----------------------------------------------------------------------------
// lpcs_mul_unit - shared registered multiply and floor shift
// One signed 16x16 product per cycle, shifted right 15 or 7, with the
// result held in an output register.
// ----------------------------------------------------------------------------
module lpcs_mul_unit (
    input  logic                i_clk,
    input  lpcs_pkg::t_mul_req  i_req,
    output logic signed [24:0]  o_prod
);
    logic signed [31:0] w_full;
    logic signed [24:0] n_prod;
    logic signed [24:0] r_prod;

    assign w_full = i_req.coef * i_req.data;
    assign n_prod = i_req.wide ? 25'(w_full >>> 15) : 25'(w_full >>> 7);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;
endmodule

@@ src/lpc_lattice_speech_synth_core.sv @@
// ----------------------------------------------------------------------------
// lpc_lattice_speech_synth_core - LPC-10 lattice speech synthesizer
// Frame words load energy, pitch and reflection coefficients; tick words
// run excitation and a ten-stage lattice filter on one shared multiplier.
//
// Usage:
//   Input channel: i_valid / o_stall with i_kind and i_frame_bits. A frame
//   word (kind 0) is decoded in ST_FRAME and gives no output word. A tick
//   word (kind 1) makes one output word on o_valid / i_stall carrying
//   o_sample (clamped to -512..511) and o_pwm_duty.
//   A voiced tick runs the chirp product (issue, then scale), the backward
//   pass (ten multiplies, each issued and then summed), the forward delay
//   update (nine stages), then loads the output register. An unvoiced
//   tick skips the chirp product. The sequencer takes no new word until
//   the last one is finished. A frame word goes from ST_FRAME straight
//   back to idle.
//   The input is stalled while a word is at work. A finished sample sits
//   in the output register; the next word is taken while it waits, but a
//   tick finishing while the register is still full holds until it drains.
//   Reset: synchronous, active low; clears all coefficients, delays, the
//   pitch counter and energy, sets the noise LFSR to one.
// ----------------------------------------------------------------------------
module lpc_lattice_speech_synth_core #(
    parameter int unsigned CHIRP_LENGTH = 41,
    parameter int unsigned FRAME_WIDTH  = 50
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_kind,
    input  logic [FRAME_WIDTH-1:0]  i_frame_bits,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [9:0]       o_sample,
    output logic [7:0]              o_pwm_duty
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FRAME = 6'b000010,
        ST_EXC   = 6'b000100,
        ST_BACK  = 6'b001000,
        ST_FWD   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_idx, n_idx;     // lattice stage
    logic       r_ph, n_ph;       // 0 = issue multiply, 1 = use product

    logic [7:0]         r_period, n_period;
    logic [7:0]         r_energy, n_energy;
    logic signed [15:0] r_kw [2];
    logic signed [7:0]  r_kn [8];
    logic [7:0]         r_pcount, n_pcount;
    logic [15:0]        r_lfsr, n_lfsr;
    logic signed [15:0] r_dly [10];
    logic signed [15:0] r_u [10];   // node values u0..u9
    logic signed [15:0] r_acc, n_acc;
    logic [FRAME_WIDTH-1:0] r_fbits;

    logic               r_oval, n_oval;
    logic signed [9:0]  r_sample;

    // decoder
    logic [3:0] w_ecode;
    logic [7:0] w_energy, w_period;
    logic       w_repeat;
    logic signed [15:0] w_k1, w_k2;
    logic signed [7:0]  w_kn [8];

    lpcs_frame_dec #(.FRAME_WIDTH(FRAME_WIDTH)) u_dec (
        .i_bits       (r_fbits),
        .o_energy_code(w_ecode),
        .o_energy     (w_energy),
        .o_repeat     (w_repeat),
        .o_period     (w_period),
        .o_k1         (w_k1),
        .o_k2         (w_k2),
        .o_kn         (w_kn)
    );

    lpcs_pkg::t_mul_req w_req;
    logic signed [24:0] w_prod;

    lpcs_mul_unit u_mul (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_prod(w_prod)
    );

    logic signed [15:0] w_coef;
    logic               w_accept;
    logic               w_out_take;
    logic               w_chirp_ok;
    logic signed [15:0] w_sum;
    logic signed [15:0] w_clamped;

    // Coefficient of the current stage, sign-extended.
    always_comb begin
        if (r_idx < 4'd2) w_coef = r_kw[r_idx[0]];
        else w_coef = 16'(r_kn[3'(r_idx - 4'd2)]);
    end

    assign w_accept   = i_valid && !o_stall;
    assign w_out_take = r_oval && !i_stall;
    assign o_stall    = (r_state != ST_IDLE);
    // Drop the excitation once the counter runs past the chirp.
    assign w_chirp_ok = (32'(r_pcount) < CHIRP_LENGTH)
                        && (r_pcount < 8'(lpcs_pkg::CHIRP_ROM_LEN));

    // Shared multiplier request.
    always_comb begin
        w_req = '0;
        case (r_state)
            ST_EXC: begin
                w_req.wide = 1'b0;
                w_req.coef = 16'(lpcs_pkg::chirp_rom(r_pcount[5:0]));
                w_req.data = {8'h00, r_energy};
            end
            ST_BACK, ST_FWD: begin
                w_req.wide = (r_idx < 4'd2);
                w_req.coef = w_coef;
                w_req.data = (r_state == ST_BACK) ? r_dly[r_idx] : r_u[r_idx];
            end
            default: w_req = '0;
        endcase
    end

    // Chirp product uses >>7; one more floor shift gives >>8.
    assign w_sum = (r_state == ST_BACK) ? (r_acc - 16'(w_prod))
                                        : (r_dly[r_idx] + 16'(w_prod));
    assign w_clamped = (w_sum > lpcs_pkg::CLAMP_HI) ? lpcs_pkg::CLAMP_HI :
                       (w_sum < lpcs_pkg::CLAMP_LO) ? lpcs_pkg::CLAMP_LO : w_sum;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_ph     = r_ph;
        n_period = r_period;
        n_energy = r_energy;
        n_pcount = r_pcount;
        n_lfsr   = r_lfsr;
        n_acc    = r_acc;
        n_oval   = r_oval;
        if (w_out_take) n_oval = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_kind == lpcs_pkg::KIND_FRAME) begin
                        n_state = ST_FRAME;
                    end else if (r_period != 8'd0) begin
                        // advance pitch counter, then chirp multiply
                        n_pcount = (r_pcount < r_period) ? r_pcount + 8'd1 : 8'd0;
                        n_state  = ST_EXC;
                    end else begin
                        n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? lpcs_pkg::LFSR_TAPS : 16'h0);
                        n_acc  = n_lfsr[0] ? 16'(r_energy) : -16'(r_energy);
                        n_state = ST_BACK;
                        n_idx   = 4'd9;
                        n_ph    = 1'b0;
                    end
                end
            end
            ST_FRAME: begin
                if (w_ecode == lpcs_pkg::ENERGY_REST || w_ecode == lpcs_pkg::ENERGY_STOP) begin
                    n_energy = 8'd0;
                end else begin
                    n_energy = w_energy;
                    n_period = w_period;
                end
                n_state = ST_IDLE;
            end
            ST_EXC: begin
                if (r_ph == 1'b0) begin
                    n_ph = 1'b1;
                end else begin
                    n_acc   = w_chirp_ok ? 16'(w_prod >>> 1) : 16'd0;
                    n_ph    = 1'b0;
                    n_idx   = 4'd9;
                    n_state = ST_BACK;
                end
            end
            ST_BACK: begin
                if (r_ph == 1'b0) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph  = 1'b0;
                    n_acc = w_sum;
                    if (r_idx == 4'd0) begin
                        n_idx   = 4'd8;
                        n_state = ST_FWD;
                    end else begin
                        n_idx = r_idx - 4'd1;
                    end
                end
            end
            ST_FWD: begin
                if (r_ph == 1'b0) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_idx == 4'd0) n_state = ST_DONE;
                    else n_idx = r_idx - 4'd1;
                end
            end
            ST_DONE: begin
                if (!r_oval || w_out_take) begin
                    n_oval  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_ph     <= 1'b0;
            r_period <= '0;
            r_energy <= '0;
            r_pcount <= '0;
            r_lfsr   <= 16'h0001;
            r_oval   <= 1'b0;
            r_acc    <= '0;
            for (int i = 0; i < 2; i++) r_kw[i] <= '0;
            for (int i = 0; i < 8; i++) r_kn[i] <= '0;
            for (int i = 0; i < 10; i++) r_dly[i] <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ph     <= n_ph;
            r_period <= n_period;
            r_energy <= n_energy;
            r_pcount <= n_pcount;
            r_lfsr   <= n_lfsr;
            r_oval   <= n_oval;
            r_acc    <= n_acc;
            // load coefficients on frame decode; a stop frame clears them
            if (r_state == ST_FRAME) begin
                if (w_ecode == lpcs_pkg::ENERGY_STOP) begin
                    for (int i = 0; i < 2; i++) r_kw[i] <= '0;
                    for (int i = 0; i < 8; i++) r_kn[i] <= '0;
                end else if (w_ecode != lpcs_pkg::ENERGY_REST && !w_repeat) begin
                    r_kw[0] <= w_k1;
                    r_kw[1] <= w_k2;
                    r_kn[0] <= w_kn[0];
                    r_kn[1] <= w_kn[1];
                    if (w_period != 8'd0) begin
                        for (int i = 2; i < 8; i++) r_kn[i] <= w_kn[i];
                    end
                end
            end
            // forward pass: delay i+1 = delay i + k_i * u_i, top-down;
            // the clamped output enters delay 0 only after delay 1 used it
            if (r_state == ST_FWD && r_ph) begin
                r_dly[r_idx + 4'd1] <= w_sum;
                if (r_idx == 4'd0) r_dly[0] <= r_u[0];
            end
            // load the output register only once it is free
            if (r_state == ST_DONE && (!r_oval || w_out_take)) begin
                r_sample <= r_u[0][9:0];
            end
        end
    end

    // Node values and frame bits are payload: no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) r_fbits <= i_frame_bits;
        if (r_state == ST_BACK && r_ph) begin
            r_u[r_idx] <= (r_idx == 4'd0) ? w_clamped : w_sum;
        end
    end

    assign o_valid    = r_oval;
    assign o_sample   = r_sample;
    assign o_pwm_duty = 8'(r_sample >>> 2) + 8'(lpcs_pkg::DUTY_BIAS);
endmodule

@@ src/lpcs_checker.sv @@
// ----------------------------------------------------------------------------
// lpcs_checker - port-level checks for the synthesizer
// Watches the handshakes and the duty output from outside.
// ----------------------------------------------------------------------------
module lpcs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              i_kind,
    input logic              o_valid,
    input logic              i_stall,
    input logic signed [9:0] o_sample,
    input logic [7:0]        o_pwm_duty
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample))
        else $error("output word dropped under stall");

    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pwm_duty == 8'(8'(o_sample >>> 2) + 8'h80))
        else $error("duty does not follow sample");

    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind == 1'b0 |=> o_stall)
        else $error("frame word not decoded");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind == 1'b1 |=> o_stall ##1 o_stall)
        else $error("tick released too early");
endmodule

bind lpc_lattice_speech_synth_core lpcs_checker u_lpcs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .i_kind    (i_kind),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_sample  (o_sample),
    .o_pwm_duty(o_pwm_duty)
);
